// ===== rtl/core/tree_path_kth_node_unit_macros.svh =====
// Assertion macros shared by the tree path k-th node unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TREE_PATH_KTH_NODE_UNIT_MACROS_SVH
`define TREE_PATH_KTH_NODE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define TPK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define TPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPK_ASSERT_IMPL(lbl, ante, cons, msg)
`define TPK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/tpk_pkg.sv =====
// Shared types, constants and helper functions of the tree path k-th node unit.
// Depends on nothing; tpk_if, tpk_datapath, tpk_ctrl and the top module import it.
package tpk_pkg;

  // Tree size and table shape.
  localparam int NODES   = 1024;
  localparam int LEVELS  = 10;
  localparam int NODE_W  = 10;
  localparam int DEP_W   = 10;
  localparam int STEP_W  = 11;
  localparam int LVL_W   = $clog2(LEVELS + 1);
  localparam int DPAD_W  = 2 ** LVL_W;
  localparam int ANC_DEPTH = LEVELS * NODES;
  localparam int ANC_AW  = $clog2(ANC_DEPTH);
  localparam int DEP_AW  = $clog2(NODES);
  localparam int CMP_W   = LEVELS + DEP_W + 1;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Micro-operations that the controller issues to the datapath.
  typedef enum logic [4:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_LD_DREAD,
    DP_LD_DWRITE,
    DP_LD_AREAD,
    DP_LD_AWRITE,
    DP_Q_DA,
    DP_Q_DB,
    DP_Q_DB2,
    DP_Q_SWAP,
    DP_LIFT_CHK,
    DP_LIFT_A,
    DP_LIFT_D,
    DP_LVL_DEC,
    DP_M_INIT,
    DP_M2_A,
    DP_M2_B,
    DP_M2_UPD,
    DP_M2_P,
    DP_M2_T,
    DP_TOP_D,
    DP_TOP_E,
    DP_EVAL,
    DP_CL_CHK,
    DP_CL_A,
    DP_CL_N,
    DP_CL_END,
    DP_OUT
  } dp_op_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LD_DR,
    ST_LD_DW,
    ST_LD_CHK,
    ST_LD_AW,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_DB2,
    ST_Q_SWAP,
    ST_LIFT_CHK,
    ST_LIFT_A,
    ST_LIFT_D,
    ST_LIFT_N,
    ST_M_INIT,
    ST_M2_A,
    ST_M2_B,
    ST_M2_UPD,
    ST_M2_P,
    ST_M2_T,
    ST_TOP_D,
    ST_TOP_E,
    ST_EVAL,
    ST_CL_CHK,
    ST_CL_A,
    ST_CL_N,
    ST_CL_END,
    ST_FIN
  } tpk_state_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
  } tpk_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_load;
    logic lvl_end;
    logic lvl_zero;
    logic lvl_last;
    logic lift_take;
    logic a_eq_b;
    logic need_climb;
    logic bit_set;
    logic out_free;
    logic out_valid;
  } tpk_status_t;

  // Flat address of ancestor row "row" for node "n".
  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] row,
                                                 input logic [NODE_W-1:0] n);
    anc_addr = ANC_AW'(ANC_AW'(row) * ANC_AW'(NODES) + ANC_AW'(n));
  endfunction

endpackage

// ===== rtl/core/tpk_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
// Depends on tpk_pkg for the payload widths.
interface tpk_in_if import tpk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [NODE_W-1:0]   first_node;
  logic [NODE_W-1:0]   parent_node;
  logic [NODE_W-1:0]   second_node;
  logic [STEP_W-1:0]   steps;

  modport source (output valid, op, first_node, parent_node, second_node, steps,
                  input ready);
  modport sink   (input valid, op, first_node, parent_node, second_node, steps,
                  output ready);
endinterface

interface tpk_out_if import tpk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   result_node;
  logic                out_of_range;

  modport source (output valid, result_node, out_of_range, input ready);
  modport sink   (input valid, result_node, out_of_range, output ready);
endinterface

// ===== rtl/core/tpk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tpk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tpk_datapath.sv =====
// Datapath of the tree path k-th node unit: ancestor and depth RAMs, working registers.
// Depends on tpk_pkg, tpk_ram and the assertion macro header.
`include "tree_path_kth_node_unit_macros.svh"

module tpk_datapath import tpk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  tpk_cmd_t            cmd,
  output tpk_status_t         status,
  input  logic                in_op,
  input  logic [NODE_W-1:0]   in_first,
  input  logic [NODE_W-1:0]   in_parent,
  input  logic [NODE_W-1:0]   in_second,
  input  logic [STEP_W-1:0]   in_steps,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   out_result,
  output logic                out_flag
);

  // Working registers.
  logic [NODE_W-1:0] u, v, p, a, b, ta, top, x, cur, res;
  logic [DEP_W-1:0]  da, db, du, dv, dt;
  logic [STEP_W-1:0] w, climb_len;
  logic [LVL_W-1:0]  lvl;
  logic              is_load, flag;

  // RAM ports.
  logic              anc_we;
  logic [ANC_AW-1:0] anc_waddr, anc_raddr;
  logic [NODE_W-1:0] anc_wdata, anc_rdata;
  logic              dep_we;
  logic [DEP_AW-1:0] dep_raddr;
  logic [DEP_W-1:0]  dep_wdata, dep_rdata;

  // Evaluation of path lengths.
  logic [DEP_W-1:0]  up_len, down_len;
  logic [STEP_W-1:0] path_len, up_ext, down_ext;
  logic              too_far, at_top;
  logic [DEP_W:0]    dep_inc;
  logic [CMP_W-1:0]  lift_lhs, lift_rhs;
  logic [DPAD_W-1:0] dist_pad;
  logic [LVL_W-1:0]  lvl_dec;

  tpk_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  tpk_ram #(.WIDTH(DEP_W), .DEPTH(NODES)) u_dep_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (DEP_AW'(u)),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  // Path length arithmetic for the final decision.
  always_comb begin
    up_len   = (du >= dt) ? du - dt : dt - du;
    down_len = (dv >= dt) ? dv - dt : dt - dv;
    up_ext   = STEP_W'(up_len);
    down_ext = STEP_W'(down_len);
    path_len = up_ext + down_ext;
    too_far  = w > path_len;
    at_top   = w == up_ext;
    dep_inc  = {1'b0, dep_rdata} + (DEP_W + 1)'(1);
    lift_lhs = CMP_W'(da);
    lift_rhs = CMP_W'(db) + (CMP_W'(1) << lvl);
    dist_pad = DPAD_W'(climb_len);
    lvl_dec  = (lvl == '0) ? '0 : lvl - LVL_W'(1);
  end

  // RAM address and write control per micro-operation.
  always_comb begin
    anc_we    = 1'b0;
    anc_waddr = anc_addr('0, u);
    anc_wdata = p;
    anc_raddr = anc_addr(lvl, a);
    dep_we    = 1'b0;
    dep_wdata = '0;
    dep_raddr = DEP_AW'(a);
    case (cmd.op)
      DP_LD_DREAD: dep_raddr = DEP_AW'(p);
      DP_LD_DWRITE: begin
        dep_we    = 1'b1;
        if (p == u) begin
          dep_wdata = '0;
        end else if (dep_inc > (DEP_W + 1)'(NODES - 1)) begin
          dep_wdata = DEP_W'(NODES - 1);
        end else begin
          dep_wdata = dep_inc[DEP_W-1:0];
        end
        anc_we    = 1'b1;
        anc_waddr = anc_addr('0, u);
        anc_wdata = p;
      end
      DP_LD_AREAD: anc_raddr = anc_addr(lvl - LVL_W'(1), cur);
      DP_LD_AWRITE: begin
        anc_we    = 1'b1;
        anc_waddr = anc_addr(lvl, u);
        anc_wdata = anc_rdata;
      end
      DP_Q_DA:     dep_raddr = DEP_AW'(a);
      DP_Q_DB:     dep_raddr = DEP_AW'(b);
      DP_LIFT_CHK: anc_raddr = anc_addr(lvl, a);
      DP_LIFT_A:   dep_raddr = DEP_AW'(anc_rdata);
      DP_M2_A:     anc_raddr = anc_addr(lvl, a);
      DP_M2_B:     anc_raddr = anc_addr(lvl, b);
      DP_M2_P:     anc_raddr = anc_addr('0, a);
      DP_TOP_D:    dep_raddr = DEP_AW'(top);
      DP_CL_CHK:   anc_raddr = anc_addr(lvl, x);
      default: begin
      end
    endcase
  end

  // Register updates per micro-operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
    end else begin
      case (cmd.op)
        DP_CAPTURE: begin
          is_load <= (in_op == OP_LOAD);
          u       <= in_first;
          p       <= in_parent;
          v       <= in_second;
          w       <= in_steps;
          a       <= in_first;
          b       <= in_second;
          res     <= in_first;
          flag    <= 1'b0;
          lvl     <= '0;
        end
        DP_LD_DWRITE: begin
          cur <= p;
          lvl <= LVL_W'(1);
        end
        DP_LD_AWRITE: begin
          cur <= anc_rdata;
          lvl <= lvl + LVL_W'(1);
        end
        DP_Q_DB:  da <= dep_rdata;
        DP_Q_DB2: begin
          db <= dep_rdata;
          du <= da;
          dv <= dep_rdata;
        end
        DP_Q_SWAP: begin
          if (da < db) begin
            a  <= b;
            b  <= a;
            da <= db;
            db <= da;
          end
          lvl <= LVL_W'(LEVELS - 1);
        end
        DP_LIFT_A:  a  <= anc_rdata;
        DP_LIFT_D:  da <= dep_rdata;
        DP_LVL_DEC: lvl <= lvl_dec;
        DP_M_INIT: begin
          top <= a;
          lvl <= LVL_W'(LEVELS - 1);
        end
        DP_M2_B: ta <= anc_rdata;
        DP_M2_UPD: begin
          if (ta != anc_rdata) begin
            a <= ta;
            b <= anc_rdata;
          end
          lvl <= lvl_dec;
        end
        DP_M2_T:  top <= anc_rdata;
        DP_TOP_E: dt  <= dep_rdata;
        DP_EVAL: begin
          lvl <= '0;
          if (too_far) begin
            flag <= 1'b1;
            res  <= v;
          end else if (at_top) begin
            res <= top;
          end else if (w < up_ext) begin
            x         <= u;
            climb_len <= up_ext - w;
          end else begin
            x         <= v;
            climb_len <= down_ext - (w - up_ext);
          end
        end
        DP_CL_A: begin
          x   <= anc_rdata;
          lvl <= lvl + LVL_W'(1);
        end
        DP_CL_N:   lvl <= lvl + LVL_W'(1);
        DP_CL_END: res <= x;
        default: begin
        end
      endcase
    end
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_result <= res;
      out_flag   <= flag;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.is_load    = is_load;
    status.lvl_end    = lvl == LVL_W'(LEVELS);
    status.lvl_zero   = lvl == '0;
    status.lvl_last   = lvl == LVL_W'(LEVELS - 1);
    status.lift_take  = lift_lhs >= lift_rhs;
    status.a_eq_b     = a == b;
    status.need_climb = !too_far && !at_top;
    status.bit_set    = dist_pad[lvl];
    status.out_free   = !out_valid || out_ready;
    status.out_valid  = out_valid;
  end

  // The level counter never leaves its range.
  `TPK_ASSERT_IMPL(a_lvl_range, 1'b1, lvl <= LVL_W'(LEVELS), "level counter out of range")
  // After the swap the first node is the deeper one.
  `TPK_ASSERT_NEXT(a_swap_order, cmd.op == DP_Q_SWAP, da >= db, "swap left shallower node first")
  // Lifting only moves the deeper node; the other depth stays put.
  `TPK_ASSERT_NEXT(a_lift_keeps_db, cmd.op == DP_LIFT_A || cmd.op == DP_LIFT_D, $stable(db),
                   "shallow depth changed while lifting")

endmodule

// ===== rtl/core/tpk_ctrl.sv =====
// Controller of the tree path k-th node unit: sequences loads and queries.
// Depends on tpk_pkg and the assertion macro header.
`include "tree_path_kth_node_unit_macros.svh"

module tpk_ctrl import tpk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output tpk_cmd_t    cmd,
  input  tpk_status_t status
);

  tpk_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_CAPTURE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: state_next = status.is_load ? ST_LD_DR : ST_Q_DA;
      ST_LD_DR: begin
        cmd.op     = DP_LD_DREAD;
        state_next = ST_LD_DW;
      end
      ST_LD_DW: begin
        cmd.op     = DP_LD_DWRITE;
        state_next = ST_LD_CHK;
      end
      ST_LD_CHK: begin
        if (status.lvl_end) begin
          state_next = ST_FIN;
        end else begin
          cmd.op     = DP_LD_AREAD;
          state_next = ST_LD_AW;
        end
      end
      ST_LD_AW: begin
        cmd.op     = DP_LD_AWRITE;
        state_next = ST_LD_CHK;
      end
      ST_Q_DA: begin
        cmd.op     = DP_Q_DA;
        state_next = ST_Q_DB;
      end
      ST_Q_DB: begin
        cmd.op     = DP_Q_DB;
        state_next = ST_Q_DB2;
      end
      ST_Q_DB2: begin
        cmd.op     = DP_Q_DB2;
        state_next = ST_Q_SWAP;
      end
      ST_Q_SWAP: begin
        cmd.op     = DP_Q_SWAP;
        state_next = ST_LIFT_CHK;
      end
      ST_LIFT_CHK: begin
        cmd.op     = DP_LIFT_CHK;
        state_next = status.lift_take ? ST_LIFT_A : ST_LIFT_N;
      end
      ST_LIFT_A: begin
        cmd.op     = DP_LIFT_A;
        state_next = ST_LIFT_D;
      end
      ST_LIFT_D: begin
        cmd.op     = DP_LIFT_D;
        state_next = ST_LIFT_N;
      end
      ST_LIFT_N: begin
        cmd.op     = DP_LVL_DEC;
        state_next = status.lvl_zero ? ST_M_INIT : ST_LIFT_CHK;
      end
      ST_M_INIT: begin
        cmd.op     = DP_M_INIT;
        state_next = status.a_eq_b ? ST_TOP_D : ST_M2_A;
      end
      ST_M2_A: begin
        cmd.op     = DP_M2_A;
        state_next = ST_M2_B;
      end
      ST_M2_B: begin
        cmd.op     = DP_M2_B;
        state_next = ST_M2_UPD;
      end
      ST_M2_UPD: begin
        cmd.op     = DP_M2_UPD;
        state_next = status.lvl_zero ? ST_M2_P : ST_M2_A;
      end
      ST_M2_P: begin
        cmd.op     = DP_M2_P;
        state_next = ST_M2_T;
      end
      ST_M2_T: begin
        cmd.op     = DP_M2_T;
        state_next = ST_TOP_D;
      end
      ST_TOP_D: begin
        cmd.op     = DP_TOP_D;
        state_next = ST_TOP_E;
      end
      ST_TOP_E: begin
        cmd.op     = DP_TOP_E;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.op     = DP_EVAL;
        state_next = status.need_climb ? ST_CL_CHK : ST_FIN;
      end
      ST_CL_CHK: begin
        cmd.op     = DP_CL_CHK;
        state_next = status.bit_set ? ST_CL_A : ST_CL_N;
      end
      ST_CL_A: begin
        cmd.op     = DP_CL_A;
        state_next = status.lvl_last ? ST_CL_END : ST_CL_CHK;
      end
      ST_CL_N: begin
        cmd.op     = DP_CL_N;
        state_next = status.lvl_last ? ST_CL_END : ST_CL_CHK;
      end
      ST_CL_END: begin
        cmd.op     = DP_CL_END;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.op     = DP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result handed to a free output register shows up as valid next cycle.
  `TPK_ASSERT_NEXT(a_fin_delivers, state == ST_FIN && status.out_free, status.out_valid,
                   "finished result not presented")
  // A result never waits in FIN while the output register can take it.
  `TPK_ASSERT_NEXT(a_fin_leaves, state == ST_FIN && status.out_free, state == ST_IDLE,
                   "controller stuck after result")

endmodule

// ===== rtl/core/tree_path_kth_node_unit.sv =====
// Tree path k-th node unit: binary-lifting ancestor table with path queries.
// A load transaction stores one node (parent loaded first, a root names itself as
// parent) and returns the node; a query returns the node a given number of steps
// from the first node toward the second, or flags the query and returns the end node
// when the steps exceed the path length. One transaction is worked on at a time.
// The depth lift, the common-ancestor search and the final climb visit the single read
// port of the ancestor RAM one level per step. A finished result waits in an output
// register while the next transaction is taken; a result that finds that register
// still full waits until it is free. Both tables are undefined until written; no
// clearing pass.
// Depends on tpk_pkg, tpk_if, tpk_ram, tpk_datapath and tpk_ctrl.
module tree_path_kth_node_unit import tpk_pkg::*; (
  input logic         clk,
  input logic         rst,
  tpk_in_if.sink      in_ch,
  tpk_out_if.source   out_ch
);

  tpk_cmd_t    cmd;
  tpk_status_t status;
  logic        in_ready;
  logic        out_valid;
  logic [NODE_W-1:0] out_result;
  logic        out_flag;

  tpk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  tpk_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_op      (in_ch.op),
    .in_first   (in_ch.first_node),
    .in_parent  (in_ch.parent_node),
    .in_second  (in_ch.second_node),
    .in_steps   (in_ch.steps),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result),
    .out_flag   (out_flag)
  );

  // Channel hookup.
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.result_node  = out_result;
  assign out_ch.out_of_range = out_flag;

endmodule

// ===== test/tree_path_kth_node_unit_tb.sv =====
// Testbench for the tree path k-th node unit: builds random trees by load
// transactions and checks load and query results against a binary-lifting predictor.
// Depends on tpk_pkg, tpk_if and the tree_path_kth_node_unit RTL.
`timescale 1ns / 1ps

// Holds the expected results and counts mismatches.
class path_result_board;
  typedef struct {
    logic [9:0] node;
    logic       flag;
  } path_result_t;

  path_result_t pending[$];
  int errors;

  // Prints one mismatch line and counts it.
  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void note_input(logic [9:0] node, logic flag);
    path_result_t r;
    r.node = node;
    r.flag = flag;
    pending = {pending, r};
  endfunction

  task check_result(logic [9:0] node, logic flag);
    path_result_t r;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result node %0d flag %0d", node, flag));
      return;
    end
    r = pending.pop_front();
    if (node !== r.node) begin
      report($sformatf("result_node %0d, predicted %0d", node, r.node));
    end
    if (flag !== r.flag) begin
      report($sformatf("out_of_range %0d, predicted %0d", flag, r.flag));
    end
  endtask
endclass

module tree_path_kth_node_unit_tb;
  import tpk_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpk_in_if  in_ch ();
  tpk_out_if out_ch ();

  tree_path_kth_node_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #1 clk = ~clk;

  path_result_board board = new();

  // Predictor state: ancestor rows, depths, and which nodes have been loaded.
  logic [9:0] lift_tab[LEVELS][NODES];
  logic [9:0] depth_of[NODES];
  bit         loaded[NODES];
  int         loaded_list[$];
  bit         sending_done;

  function automatic logic [9:0] climb_up(logic [9:0] x, int span);
    for (int j = 0; j < LEVELS; j++) begin
      if ((span >> j) & 1) begin
        x = lift_tab[j][x];
      end
    end
    return x;
  endfunction

  function automatic logic [9:0] common_ancestor(logic [9:0] a, logic [9:0] b);
    logic [9:0] t;
    if (depth_of[a] < depth_of[b]) begin
      t = a;
      a = b;
      b = t;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (int'(depth_of[a]) >= int'(depth_of[b]) + (1 << i)) begin
        a = lift_tab[i][a];
      end
    end
    if (a == b) begin
      return a;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lift_tab[i][a] != lift_tab[i][b]) begin
        a = lift_tab[i][a];
        b = lift_tab[i][b];
      end
    end
    return lift_tab[0][a];
  endfunction

  // Works out the result of one transaction and updates the predictor tree.
  function automatic void predict(logic op, logic [9:0] u, logic [9:0] p,
                                  logic [9:0] v, logic [10:0] w);
    logic [9:0] top;
    int up_len;
    int down_len;
    if (op == OP_LOAD) begin
      if (p == u) begin
        depth_of[u] = 0;
      end else begin
        depth_of[u] = (depth_of[p] == NODES - 1) ? 10'(NODES - 1) : depth_of[p] + 10'd1;
      end
      lift_tab[0][u] = p;
      for (int i = 1; i < LEVELS; i++) begin
        lift_tab[i][u] = lift_tab[i-1][lift_tab[i-1][u]];
      end
      if (!loaded[u]) begin
        loaded[u] = 1'b1;
        loaded_list = {loaded_list, int'(u)};
      end
      board.note_input(u, 1'b0);
    end else begin
      top = common_ancestor(u, v);
      up_len = int'(depth_of[u]) - int'(depth_of[top]);
      down_len = int'(depth_of[v]) - int'(depth_of[top]);
      if (up_len < 0) up_len = -up_len;
      if (down_len < 0) down_len = -down_len;
      if (int'(w) > up_len + down_len) begin
        board.note_input(v, 1'b1);
      end else if (int'(w) == up_len) begin
        board.note_input(top, 1'b0);
      end else if (int'(w) < up_len) begin
        board.note_input(climb_up(u, up_len - int'(w)), 1'b0);
      end else begin
        board.note_input(climb_up(v, down_len - (int'(w) - up_len)), 1'b0);
      end
    end
  endfunction

  // Sends one transaction after a random gap and waits for its acceptance.
  task automatic send_item(logic op, logic [9:0] u, logic [9:0] p,
                           logic [9:0] v, logic [10:0] w);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.first_node  <= u;
    in_ch.parent_node <= p;
    in_ch.second_node <= v;
    in_ch.steps       <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict(op, u, p, v, w);
  endtask

  function automatic logic [9:0] pick_loaded();
    return 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // Loads a node under a loaded parent (the latest or a random one), or as a root.
  task automatic load_random(logic [9:0] u, bit as_root, bit deep);
    logic [9:0] p;
    if (as_root || loaded_list.size() == 0) begin
      p = u;
    end else if (deep) begin
      p = 10'(loaded_list[loaded_list.size() - 1]);
    end else begin
      p = pick_loaded();
    end
    send_item(OP_LOAD, u, p, 10'($urandom), 11'($urandom));
  endtask

  task automatic query_random();
    logic [9:0] a;
    logic [9:0] b;
    logic [10:0] w;
    a = pick_loaded();
    b = pick_loaded();
    case ($urandom_range(0, 3))
      0: w = 11'($urandom);
      1: w = 11'($urandom_range(0, 8));
      default: w = 11'($urandom_range(0, 80));
    endcase
    send_item(OP_QUERY, a, 10'($urandom), b, w);
  endtask

  // Result side: a random wait before each result, then checks the accepted result.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_result(out_ch.result_node, out_ch.out_of_range);
    end
  end

  // Stimulus and end of run.
  initial begin
    int chain_u;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_LOAD;
    in_ch.first_node  = '0;
    in_ch.parent_node = '0;
    in_ch.second_node = '0;
    in_ch.steps       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: root at the top node number, a chain, extreme nodes and steps.
    send_item(OP_LOAD, 10'd1023, 10'd1023, 10'd0, 11'd2047);
    send_item(OP_LOAD, 10'd0, 10'd1023, 10'd1023, 11'd0);
    send_item(OP_LOAD, 10'd1, 10'd0, 10'd0, 11'd0);
    send_item(OP_LOAD, 10'd2, 10'd0, 10'd0, 11'd0);
    send_item(OP_LOAD, 10'd3, 10'd1, 10'd0, 11'd0);
    send_item(OP_QUERY, 10'd3, 10'd0, 10'd2, 11'd0);
    send_item(OP_QUERY, 10'd3, 10'd0, 10'd2, 11'd2);
    send_item(OP_QUERY, 10'd3, 10'd0, 10'd2, 11'd3);
    send_item(OP_QUERY, 10'd3, 10'd0, 10'd2, 11'd4);
    send_item(OP_QUERY, 10'd3, 10'd1023, 10'd2, 11'd5);
    send_item(OP_QUERY, 10'd3, 10'd0, 10'd2, 11'd2047);
    send_item(OP_QUERY, 10'd1023, 10'd0, 10'd1023, 11'd0);
    send_item(OP_QUERY, 10'd1023, 10'd0, 10'd1023, 11'd1);
    send_item(OP_QUERY, 10'd1, 10'd0, 10'd3, 11'd1);
    send_item(OP_QUERY, 10'd2, 10'd0, 10'd1023, 11'd1);

    // Hold off until every predicted result has come back.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);

    // Build a long chain so that deep lifts are used.
    chain_u = 3;
    for (int k = 4; k < 300; k++) begin
      send_item(OP_LOAD, 10'(k), 10'(chain_u), 10'($urandom), 11'($urandom));
      chain_u = k;
    end

    // Random part: mostly queries, with loads of fresh or reloaded nodes.
    for (int n = 0; n < 540; n++) begin
      case ($urandom_range(0, 9))
        0: load_random(10'($urandom_range(300, 1022)), $urandom_range(0, 15) == 0,
                       1'($urandom_range(0, 1)));
        1: load_random(10'($urandom_range(300, 1022)), 1'b0, 1'b0);
        default: query_random();
      endcase
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
